FILE: src/utf8_to_utf16_transcoder_assert.svh
// Assertion helpers shared by the transcoder modules. They expect clk and rst
// to be visible in the module that uses them.
`ifndef UTF8_TO_UTF16_TRANSCODER_ASSERT_SVH
`define UTF8_TO_UTF16_TRANSCODER_ASSERT_SVH

// Checks a condition at every clock edge outside reset.
`define UTT_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("transcoder assertion failed");

// Checks that the consequent holds in the same cycle as the antecedent.
`define UTT_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("transcoder assertion failed");

`endif

FILE: src/utt_pkg.sv
`default_nettype none

package utt_pkg;

  localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;
  localparam int unsigned CP_W = 21;

  localparam logic [CP_W-1:0] CP_MAX = 21'h10FFFF;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_LEAD  = 2'd1,
    ST_TRUNCATED = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  // One decoded event passed from the front end to the back end.
  typedef struct packed {
    logic [CP_W-1:0] cp;
    status_t         status;
    logic            last;
  } entry_t;

endpackage

`default_nettype wire

FILE: src/utt_fifo.sv
`default_nettype none

module utt_fifo #(
  parameter int unsigned DEPTH = utt_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire utt_pkg::entry_t wr_data,
  output logic                full,
  input  wire logic           pop,
  output logic                rd_valid,
  output utt_pkg::entry_t     rd_data
);
  import utt_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  entry_t             slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full     = (count == CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

`include "utf8_to_utf16_transcoder_assert.svh"

  `UTT_ASSERT_ALWAYS(a_count_bound, count <= CNT_W'(DEPTH))
  `UTT_ASSERT_IMPLY(a_no_overflow, push, !full || pop)
  `UTT_ASSERT_IMPLY(a_no_underflow, pop, rd_valid)

endmodule

`default_nettype wire

FILE: src/utt_front.sv
`default_nettype none

module utt_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [7:0]      in_byte,
  input  wire logic            string_last,
  input  wire logic            queue_full,
  output logic                 push,
  output utt_pkg::entry_t      push_data
);
  import utt_pkg::*;

  logic [CP_W-1:0] partial_point;
  logic [1:0]      bytes_left;

  logic [CP_W-1:0] point_next;
  logic [1:0]      left_next;
  logic            accept;
  logic            bad_lead;
  logic            done;
  logic            truncated;

  assign in_stall = queue_full;
  assign accept   = in_valid && !queue_full;

  always_comb begin
    point_next = partial_point;
    left_next  = bytes_left;
    bad_lead   = 1'b0;
    done       = 1'b0;
    if (bytes_left == 2'd0) begin
      if (in_byte[7] == 1'b0) begin
        point_next = CP_W'(in_byte);
        done       = 1'b1;
      end else if ((in_byte & 8'hE0) == 8'hC0) begin
        point_next = CP_W'(in_byte & 8'h1F);
        left_next  = 2'd1;
      end else if ((in_byte & 8'hF0) == 8'hE0) begin
        point_next = CP_W'(in_byte & 8'h0F);
        left_next  = 2'd2;
      end else if ((in_byte & 8'hF8) == 8'hF0) begin
        point_next = CP_W'(in_byte & 8'h07);
        left_next  = 2'd3;
      end else begin
        bad_lead = 1'b1;
      end
    end else begin
      // Continuation bytes contribute their low six bits without a check.
      point_next = {partial_point[CP_W-7:0], in_byte[5:0]};
      left_next  = bytes_left - 2'd1;
      done       = (left_next == 2'd0);
    end
    truncated = string_last && (left_next != 2'd0);
  end

  always_comb begin
    push_data.last = string_last;
    push_data.cp   = '0;
    if (bad_lead) begin
      push_data.status = ST_BAD_LEAD;
    end else if (truncated) begin
      push_data.status = ST_TRUNCATED;
    end else if (point_next > CP_MAX) begin
      push_data.status = ST_RANGE;
    end else begin
      push_data.status = ST_OK;
      push_data.cp     = point_next;
    end
  end

  assign push = accept && (bad_lead || done || truncated);

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_point <= '0;
      bytes_left    <= '0;
    end else if (accept) begin
      partial_point <= (done || truncated) ? '0 : point_next;
      bytes_left    <= truncated ? 2'd0 : left_next;
    end
  end

endmodule

`default_nettype wire

FILE: src/utt_back.sv
`default_nettype none

module utt_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            swap_output,
  input  wire logic            rd_valid,
  input  wire utt_pkg::entry_t rd_data,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic [15:0]          code_unit,
  output logic [1:0]           status,
  output logic                 run_last,
  output logic                 string_end
);
  import utt_pkg::*;

  // Set after the high surrogate of a pair has gone out.
  logic        half;
  logic        load;
  logic        pair;
  logic        final_beat;
  logic [4:0]  plane;
  logic [15:0] unit;
  logic [15:0] unit_swapped;

  assign pair       = (rd_data.status == ST_OK) && (rd_data.cp[20:16] != 5'd0);
  assign final_beat = !pair || half;
  assign plane      = rd_data.cp[20:16] - 5'd1;
  assign load       = rd_valid && (!out_valid || !out_stall);
  assign pop        = load && final_beat;

  always_comb begin
    if (rd_data.status != ST_OK) begin
      unit = '0;
    end else if (pair && !half) begin
      unit = {6'b110110, plane[3:0], rd_data.cp[15:10]};
    end else if (pair) begin
      unit = {6'b110111, rd_data.cp[9:0]};
    end else begin
      unit = rd_data.cp[15:0];
    end
    unit_swapped = swap_output ? {unit[7:0], unit[15:8]} : unit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      half      <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        half      <= !final_beat;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      code_unit  <= unit_swapped;
      status     <= 2'(rd_data.status);
      run_last   <= final_beat;
      string_end <= final_beat && rd_data.last;
    end
  end

`include "utf8_to_utf16_transcoder_assert.svh"

  `UTT_ASSERT_IMPLY(a_half_on_pair, half, rd_valid && pair)

endmodule

`default_nettype wire

FILE: src/utf8_to_utf16_transcoder.sv
// UTF-8 to UTF-16 transcoder. One UTF-8 byte is taken per cycle on the input
// channel as long as the internal event queue (QUEUE_DEPTH entries) has room;
// the front end decodes each byte in the cycle it arrives and queues one entry
// per completed, failed or truncated sequence. The back end drains the queue
// into a registered output, one code unit at a time, held while out_stall
// is set; a code point of 0x10000 or above goes out as a surrogate pair of
// two code units. A byte's first result passes a queue slot, then the output
// register. Error results carry a code unit of zero. swap_output may only be
// written while the block is idle; the configuration channel is always ready.
`default_nettype none

module utf8_to_utf16_transcoder #(
  parameter int unsigned QUEUE_DEPTH = utt_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  input  wire logic        string_last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      code_unit,
  output logic [1:0]       status,
  output logic             run_last,
  output logic             string_end,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data
);
  import utt_pkg::*;

  logic   swap_output;
  logic   queue_full;
  logic   push;
  entry_t push_data;
  logic   pop;
  logic   rd_valid;
  entry_t rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      swap_output <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      swap_output <= cfg_data;
    end
  end

  utt_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .string_last (string_last),
    .queue_full  (queue_full),
    .push        (push),
    .push_data   (push_data)
  );

  utt_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_data  (push_data),
    .full     (queue_full),
    .pop      (pop),
    .rd_valid (rd_valid),
    .rd_data  (rd_data)
  );

  utt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .swap_output (swap_output),
    .rd_valid    (rd_valid),
    .rd_data     (rd_data),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .code_unit   (code_unit),
    .status      (status),
    .run_last    (run_last),
    .string_end  (string_end)
  );

endmodule

`default_nettype wire
